// ===== hw/rtl/pus_pkg.sv =====
`default_nettype none

package pus_pkg;

  // Default fraction width of the fixed-point format
  localparam int FRAC_BITS_DEF = 16;

  // Configuration port shape
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 32;

  // Register reset values
  localparam logic [16:0]        TIME_STEP_RST = 17'd3277;
  localparam logic signed [23:0] WIND_RST      = 24'sd0;
  localparam logic [19:0]        DRAG_RST      = 20'd19661;
  localparam logic signed [31:0] FLOOR_RST     = 32'sd0;
  localparam logic [26:0]        SIZE_LIM_RST  = 27'd196608;
  localparam logic signed [27:0] GROWTH_RST    = 28'sd0;

  // Width of the precomputed per-step coefficients
  localparam int CoefW = 47;

  // Configuration register map
  typedef enum logic [CfgIdxW-1:0] {
    REG_TIME_STEP = 4'd0,
    REG_WIND_X    = 4'd1,
    REG_WIND_Y    = 4'd2,
    REG_WIND_Z    = 4'd3,
    REG_DRAG      = 4'd4,
    REG_FLOOR     = 4'd5,
    REG_SIZE_LIM  = 4'd6,
    REG_GROWTH    = 4'd7
  } pus_reg_e;

  // One particle record in
  typedef struct packed {
    logic              alive_in;
    logic              burn_mode;
    logic signed [31:0] pos_x_in;
    logic signed [31:0] pos_y_in;
    logic signed [31:0] pos_z_in;
    logic signed [31:0] vel_x_in;
    logic signed [31:0] vel_y_in;
    logic signed [31:0] vel_z_in;
    logic signed [31:0] life_left_in;
    logic [30:0]       age_in;
    logic [26:0]       size_in;
  } pus_item_t;

  // One particle record out
  typedef struct packed {
    logic              alive_out;
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [31:0] pos_z_out;
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_y_out;
    logic signed [31:0] vel_z_out;
    logic signed [31:0] life_left_out;
    logic [30:0]       age_out;
    logic [26:0]       size_out;
    logic [23:0]       color_rgb;
    logic              color_update;
  } pus_result_t;

  // Register contents plus per-step coefficients derived from them
  typedef struct packed {
    logic [16:0]             time_step;
    logic signed [23:0]      wind_x;
    logic signed [23:0]      wind_y;
    logic signed [23:0]      wind_z;
    logic signed [31:0]      floor_elevation;
    logic [26:0]             size_limit;
    logic signed [31:0]      k;         // one - drag*dt
    logic signed [CoefW-1:0] gdt_norm;  // gravity*dt, normal mode
    logic signed [CoefW-1:0] gdt_burn;  // gravity*dt, burn mode
    logic signed [CoefW-1:0] grow_dt;   // growth*dt
  } pus_coef_t;

endpackage

`default_nettype wire

// ===== hw/rtl/particle_update_step.sv =====
`default_nettype none

// One Euler step per particle record. The datapath is a five-register
// pipeline that takes one record per clock: busy stays low, a record is
// taken whenever start is high, and its result sits on result_o with
// out_strb_o high for one cycle, in order of acceptance. The five
// registers are the input register, one after the drag multiply, one
// after the velocity sum, one after the velocity-times-dt multiply, and
// the output register. The result cannot be held off, so it must be
// captured in its strobe cycle. Coefficients derived from dt, drag and
// growth are recomputed into registers after a register write; a record
// accepted at the edge after the write already sees them. Write the
// registers only while no record is in flight. FRAC_BITS sets the
// fixed-point fraction width (8 to 24); port widths do not change.
module particle_update_step #(
  parameter int FRAC_BITS = pus_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  pus_pkg::pus_item_t                item_i,
  output logic                              out_strb_o,
  output pus_pkg::pus_result_t              result_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [pus_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [pus_pkg::CfgDataW-1:0] cfg_data_i
);

  pus_pkg::pus_coef_t coef;
  logic               accept;

  // The pipeline never stalls; take every beat
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  pus_cfg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  pus_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (accept),
    .item_i    (item_i),
    .coef_i    (coef),
    .out_vld_o (out_strb_o),
    .result_o  (result_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/pus_cfg.sv =====
`default_nettype none

module pus_cfg #(
  parameter int FRAC_BITS = pus_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [pus_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [pus_pkg::CfgDataW-1:0]  cfg_data_i,
  output pus_pkg::pus_coef_t                 coef_o
);

  localparam longint GyNormL = -(((longint'(98) << FRAC_BITS) + longint'(5)) / longint'(10));
  localparam logic signed [28:0] GyNorm = 29'(GyNormL);
  localparam logic signed [28:0] GyBurn = 29'(longint'(3) << FRAC_BITS);
  localparam logic signed [31:0] One    = 32'(longint'(1) << FRAC_BITS);

  logic [16:0]        time_step_q;
  logic signed [23:0] wind_x_q, wind_y_q, wind_z_q;
  logic [19:0]        drag_q;
  logic signed [31:0] floor_q;
  logic [26:0]        size_lim_q;
  logic signed [27:0] growth_q;

  logic signed [17:0]               dts;
  logic [36:0]                      drag_dt;
  logic signed [31:0]               k_d, k_q;
  logic signed [pus_pkg::CoefW-1:0] gn_prod, gb_prod, gr_prod;
  logic signed [pus_pkg::CoefW-1:0] gdt_norm_q, gdt_burn_q, grow_dt_q;

  // Write a register on each accepted beat; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= pus_pkg::TIME_STEP_RST;
      wind_x_q    <= pus_pkg::WIND_RST;
      wind_y_q    <= pus_pkg::WIND_RST;
      wind_z_q    <= pus_pkg::WIND_RST;
      drag_q      <= pus_pkg::DRAG_RST;
      floor_q     <= pus_pkg::FLOOR_RST;
      size_lim_q  <= pus_pkg::SIZE_LIM_RST;
      growth_q    <= pus_pkg::GROWTH_RST;
    end else if (cfg_valid_i) begin
      unique case (pus_pkg::pus_reg_e'(cfg_index_i))
        pus_pkg::REG_TIME_STEP: time_step_q <= cfg_data_i[16:0];
        pus_pkg::REG_WIND_X:    wind_x_q    <= cfg_data_i[23:0];
        pus_pkg::REG_WIND_Y:    wind_y_q    <= cfg_data_i[23:0];
        pus_pkg::REG_WIND_Z:    wind_z_q    <= cfg_data_i[23:0];
        pus_pkg::REG_DRAG:      drag_q      <= cfg_data_i[19:0];
        pus_pkg::REG_FLOOR:     floor_q     <= cfg_data_i[31:0];
        pus_pkg::REG_SIZE_LIM:  size_lim_q  <= cfg_data_i[26:0];
        pus_pkg::REG_GROWTH:    growth_q    <= cfg_data_i[27:0];
        default: ;
      endcase
    end
  end

  // Form the per-step products from dt
  assign dts     = $signed({1'b0, time_step_q});
  assign drag_dt = 37'(drag_q) * 37'(time_step_q);
  assign k_d     = One - 32'(drag_dt >> FRAC_BITS);
  assign gn_prod = 47'(GyNorm) * 47'(dts);
  assign gb_prod = 47'(GyBurn) * 47'(dts);
  assign gr_prod = 47'(growth_q) * 47'(dts);

  // Hold the coefficients in registers, with the products floored to the fixed-point grid
  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    gdt_norm_q <= gn_prod >>> FRAC_BITS;
    gdt_burn_q <= gb_prod >>> FRAC_BITS;
    grow_dt_q  <= gr_prod >>> FRAC_BITS;
  end

  always_comb begin
    coef_o.time_step       = time_step_q;
    coef_o.wind_x          = wind_x_q;
    coef_o.wind_y          = wind_y_q;
    coef_o.wind_z          = wind_z_q;
    coef_o.floor_elevation = floor_q;
    coef_o.size_limit      = size_lim_q;
    coef_o.k               = k_q;
    coef_o.gdt_norm        = gdt_norm_q;
    coef_o.gdt_burn        = gdt_burn_q;
    coef_o.grow_dt         = grow_dt_q;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pus_pipe.sv =====
`default_nettype none

module pus_pipe #(
  parameter int FRAC_BITS = pus_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_vld_i,
  input  pus_pkg::pus_item_t item_i,
  input  pus_pkg::pus_coef_t coef_i,
  output logic               out_vld_o,
  output pus_pkg::pus_result_t result_o
);

  localparam int Lw = FRAC_BITS + 2;
  localparam int Sw = Lw + 8;
  localparam logic [30:0]   AgeHalf    = 31'(longint'(1) << (FRAC_BITS - 1));
  localparam logic [30:0]   AgeOne     = 31'(longint'(1) << FRAC_BITS);
  localparam logic [30:0]   AgeOneHalf = 31'(longint'(3) << (FRAC_BITS - 1));
  localparam logic [Lw-1:0] LvOne      = Lw'(longint'(1) << FRAC_BITS);
  localparam logic [Lw-1:0] LvTwo      = Lw'(longint'(2) << FRAC_BITS);
  localparam logic [Lw-1:0] LvThree    = Lw'(longint'(3) << FRAC_BITS);
  localparam logic [Sw-1:0] ChanRound  = Sw'(longint'(1) << (FRAC_BITS - 1));

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

  // Shared views of the configuration
  logic signed [17:0] dts;
  logic signed [23:0] w [3];

  assign dts  = $signed({1'b0, coef_i.time_step});
  assign w[0] = coef_i.wind_x;
  assign w[1] = coef_i.wind_y;
  assign w[2] = coef_i.wind_z;

  // ---------------- stage A: registered input beat ----------------
  logic               a_vld_q;
  pus_pkg::pus_item_t a_item_q;
  logic signed [31:0] a_v [3];
  logic signed [31:0] a_p [3];
  logic signed [32:0] life_sum;
  logic signed [31:0] life_new;
  logic [31:0]        age_sum;
  logic [30:0]        age_new;
  logic signed [47:0] size_sum;
  logic [26:0]        size_new;
  logic signed [32:0] diff [3];
  logic signed [64:0] prod_d [3];
  logic               live_d;
  logic signed [31:0] life_d;
  logic [30:0]        age_d;
  logic [26:0]        size_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_item_q <= item_i;
  end

  assign a_v[0] = a_item_q.vel_x_in;
  assign a_v[1] = a_item_q.vel_y_in;
  assign a_v[2] = a_item_q.vel_z_in;
  assign a_p[0] = a_item_q.pos_x_in;
  assign a_p[1] = a_item_q.pos_y_in;
  assign a_p[2] = a_item_q.pos_z_in;

  // Step life and age, grow size, form drag products
  always_comb begin
    life_sum = 33'(a_item_q.life_left_in) - 33'(dts);
    life_new = sat32(66'(life_sum));
    age_sum  = 32'(a_item_q.age_in) + 32'(coef_i.time_step);
    age_new  = age_sum[31] ? {31{1'b1}} : age_sum[30:0];
    live_d   = a_item_q.alive_in && (life_new > 32'sd0);

    size_sum = 48'($signed({1'b0, a_item_q.size_in})) + 48'(coef_i.grow_dt);
    if (a_item_q.size_in >= coef_i.size_limit) begin
      size_new = a_item_q.size_in;
    end else if (size_sum < 48'sd0) begin
      size_new = '0;
    end else if (size_sum > 48'sd134217727) begin
      size_new = {27{1'b1}};
    end else begin
      size_new = size_sum[26:0];
    end

    life_d = a_item_q.alive_in ? life_new : a_item_q.life_left_in;
    age_d  = live_d ? age_new : a_item_q.age_in;
    size_d = live_d ? size_new : a_item_q.size_in;

    for (int i = 0; i < 3; i++) begin
      diff[i]   = 33'(a_v[i]) - 33'(w[i]);
      prod_d[i] = 65'(diff[i]) * 65'(coef_i.k);
    end
  end

  // ---------------- stage B: drag products registered ----------------
  logic               b_vld_q, b_live_q, b_burn_q;
  logic signed [31:0] b_life_q;
  logic [30:0]        b_age_q;
  logic [26:0]        b_size_q;
  logic signed [31:0] b_p_q [3];
  logic signed [31:0] b_v_q [3];
  logic signed [64:0] b_prod_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_live_q <= live_d;
    b_burn_q <= a_item_q.burn_mode;
    b_life_q <= life_d;
    b_age_q  <= age_d;
    b_size_q <= size_d;
    for (int i = 0; i < 3; i++) begin
      b_p_q[i]    <= a_p[i];
      b_v_q[i]    <= a_v[i];
      b_prod_q[i] <= prod_d[i];
    end
  end

  // New velocity: wind plus relaxed difference plus gravity
  logic signed [pus_pkg::CoefW-1:0] grav [3];
  logic signed [65:0]               vsum [3];
  logic signed [31:0]               vel_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      grav[i] = '0;
      if (i == 1) begin
        grav[i] = b_burn_q ? coef_i.gdt_burn : coef_i.gdt_norm;
      end
      vsum[i]  = 66'(w[i]) + 66'(b_prod_q[i] >>> FRAC_BITS) + 66'(grav[i]);
      vel_d[i] = b_live_q ? sat32(vsum[i]) : b_v_q[i];
    end
  end

  // Burn color ramp: white, yellow, red, black
  logic [Lw-1:0] age2;
  logic [Lw-1:0] lvl;
  logic [Sw-1:0] scaled;
  logic [7:0]    chan;
  logic          cupd_d;
  logic [23:0]   color_d;

  always_comb begin
    age2   = {b_age_q[FRAC_BITS:0], 1'b0};
    cupd_d = b_live_q && b_burn_q && (b_age_q < AgeOneHalf);
    if (b_age_q < AgeHalf) begin
      lvl = LvOne - age2;
    end else if (b_age_q < AgeOne) begin
      lvl = LvTwo - age2;
    end else begin
      lvl = LvThree - age2;
    end
    scaled = {lvl, 8'b0} - Sw'(lvl) + ChanRound;
    chan   = scaled[FRAC_BITS +: 8];
    if (!cupd_d) begin
      color_d = '0;
    end else if (b_age_q < AgeHalf) begin
      color_d = {8'hFF, 8'hFF, chan};
    end else if (b_age_q < AgeOne) begin
      color_d = {8'hFF, chan, 8'h00};
    end else begin
      color_d = {chan, 8'h00, 8'h00};
    end
  end

  // ---------------- stage C: new velocity registered ----------------
  logic               c_vld_q, c_live_q, c_cupd_q;
  logic signed [31:0] c_life_q;
  logic [30:0]        c_age_q;
  logic [26:0]        c_size_q;
  logic [23:0]        c_color_q;
  logic signed [31:0] c_p_q [3];
  logic signed [31:0] c_v_q [3];
  logic signed [49:0] pv_d [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_live_q  <= b_live_q;
    c_cupd_q  <= cupd_d;
    c_life_q  <= b_life_q;
    c_age_q   <= b_age_q;
    c_size_q  <= b_size_q;
    c_color_q <= color_d;
    for (int i = 0; i < 3; i++) begin
      c_p_q[i] <= b_p_q[i];
      c_v_q[i] <= vel_d[i];
    end
  end

  // Position increment product
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pv_d[i] = 50'(c_v_q[i]) * 50'(dts);
    end
  end

  // ---------------- stage D: increment registered ----------------
  logic               d_vld_q, d_live_q, d_cupd_q;
  logic signed [31:0] d_life_q;
  logic [30:0]        d_age_q;
  logic [26:0]        d_size_q;
  logic [23:0]        d_color_q;
  logic signed [31:0] d_p_q [3];
  logic signed [31:0] d_v_q [3];
  logic signed [49:0] d_pv_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_live_q  <= c_live_q;
    d_cupd_q  <= c_cupd_q;
    d_life_q  <= c_life_q;
    d_age_q   <= c_age_q;
    d_size_q  <= c_size_q;
    d_color_q <= c_color_q;
    for (int i = 0; i < 3; i++) begin
      d_p_q[i]  <= c_p_q[i];
      d_v_q[i]  <= c_v_q[i];
      d_pv_q[i] <= pv_d[i];
    end
  end

  // Integrate position and test the floor
  logic signed [65:0]   psum [3];
  logic signed [31:0]   pos_d [3];
  logic                 alive_d;
  pus_pkg::pus_result_t res_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i]  = 66'(d_p_q[i]) + 66'(d_pv_q[i] >>> FRAC_BITS);
      pos_d[i] = d_live_q ? sat32(psum[i]) : d_p_q[i];
    end
    alive_d = d_live_q && !(pos_d[1] < coef_i.floor_elevation);

    res_d.alive_out     = alive_d;
    res_d.pos_x_out     = pos_d[0];
    res_d.pos_y_out     = pos_d[1];
    res_d.pos_z_out     = pos_d[2];
    res_d.vel_x_out     = d_v_q[0];
    res_d.vel_y_out     = d_v_q[1];
    res_d.vel_z_out     = d_v_q[2];
    res_d.life_left_out = d_life_q;
    res_d.age_out       = d_age_q;
    res_d.size_out      = d_size_q;
    res_d.color_rgb     = d_color_q;
    res_d.color_update  = d_cupd_q;
  end

  // ---------------- output register ----------------
  logic                 out_vld_q;
  pus_pkg::pus_result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_vld_o = out_vld_q;
  assign result_o  = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pus_checker.sv =====
`default_nettype none

module pus_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 start,
  input wire logic                 busy,
  input pus_pkg::pus_item_t        item_i,
  input wire logic                 out_strb_o,
  input pus_pkg::pus_result_t      result_o
);

  // Every accepted beat yields a result strobe
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 out_strb_o)
    else $error("accepted record produced no result");

  // No result without an accepted beat behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strb_o |-> $past(start && !busy, 5))
    else $error("result strobe without accepted record");

  // A dead record stays dead and never updates color
  a_dead_stays_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !item_i.alive_in) |->
      ##5 (!result_o.alive_out && !result_o.color_update))
    else $error("dead record came back alive or colored");

  // Color only changes for a burning record
  a_color_needs_burn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strb_o && result_o.color_update) |-> $past(item_i.burn_mode, 5))
    else $error("color update for a record not in burn mode");

endmodule

bind particle_update_step pus_checker u_pus_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .item_i     (item_i),
  .out_strb_o (out_strb_o),
  .result_o   (result_o)
);

`default_nettype wire
